// ===== src/ats_pkg.sv =====
// Shared types, register indexes and saturating helpers for the step detector.
// Used by the channel interfaces and the top level; depends on nothing else.
`default_nettype none

package ats_pkg;

  // Field widths of the sample and result beats.
  localparam int SAMPLE_W = 16;
  localparam int TIME_W   = 32;
  localparam int COUNT_W  = 24;
  localparam int LEVEL_W  = 33;
  localparam int WEIGHT_W = 17;
  localparam int DECAY_W  = 16;
  localparam int HOLD_W   = 16;

  // Configuration port shape.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 33;

  typedef logic signed [LEVEL_W-1:0] level_t;
  typedef logic signed [35:0]        wide_t;
  typedef logic [CFG_IDX_W-1:0]      cfg_idx_t;

  // Register indexes.
  localparam cfg_idx_t CFG_FILTER_WEIGHT  = 3'd0;
  localparam cfg_idx_t CFG_ZERO_OFFSET    = 3'd1;
  localparam cfg_idx_t CFG_TOP_FLOOR      = 3'd2;
  localparam cfg_idx_t CFG_TOP_CEILING    = 3'd3;
  localparam cfg_idx_t CFG_BOTTOM_CEILING = 3'd4;
  localparam cfg_idx_t CFG_BOTTOM_FLOOR   = 3'd5;
  localparam cfg_idx_t CFG_DECAY_STEP     = 3'd6;
  localparam cfg_idx_t CFG_HOLD_MS        = 3'd7;

  // Reset values of the registers.
  localparam logic [WEIGHT_W-1:0] RST_FILTER_WEIGHT  = 17'd58982;
  localparam logic signed [SAMPLE_W-1:0] RST_ZERO_OFFSET = 16'sd1300;
  localparam level_t              RST_TOP_FLOOR      = 33'sd32768;
  localparam level_t              RST_TOP_CEILING    = 33'sd98304;
  localparam level_t              RST_BOTTOM_CEILING = -33'sd32768;
  localparam level_t              RST_BOTTOM_FLOOR   = -33'sd98304;
  localparam logic [DECAY_W-1:0]  RST_DECAY_STEP     = 16'd33;
  localparam logic [HOLD_W-1:0]   RST_HOLD_MS        = 16'd100;

  // Q16.16 unity and its negation, used for threshold reset values.
  localparam level_t LEVEL_ONE     = 33'sd65536;
  localparam level_t LEVEL_NEG_ONE = -33'sd65536;
  localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = 17'd65536;
  localparam logic [COUNT_W-1:0]  COUNT_MAX  = {COUNT_W{1'b1}};

  localparam wide_t LEVEL_MAX_W = 36'sh0FFFFFFFF;
  localparam wide_t LEVEL_MIN_W = 36'shF00000000;

  // Clamp a wide signed value to the 33-bit level range.
  function automatic level_t sat_level(input wide_t v);
    level_t r;
    if (v > LEVEL_MAX_W) begin
      r = LEVEL_MAX_W[LEVEL_W-1:0];
    end else if (v < LEVEL_MIN_W) begin
      r = LEVEL_MIN_W[LEVEL_W-1:0];
    end else begin
      r = v[LEVEL_W-1:0];
    end
    return r;
  endfunction

  // Level minus the decay amount, saturated.
  function automatic level_t level_sub(input level_t a, input logic [DECAY_W-1:0] d);
    wide_t t;
    t = {{3{a[LEVEL_W-1]}}, a} - {20'd0, d};
    return sat_level(t);
  endfunction

  // Level plus the decay amount, saturated.
  function automatic level_t level_add(input level_t a, input logic [DECAY_W-1:0] d);
    wide_t t;
    t = {{3{a[LEVEL_W-1]}}, a} + {20'd0, d};
    return sat_level(t);
  endfunction

  // Negated level, saturated (the most negative level maps to the maximum).
  function automatic level_t level_neg(input level_t a);
    wide_t t;
    t = -{{3{a[LEVEL_W-1]}}, a};
    return sat_level(t);
  endfunction

endpackage

`default_nettype wire

// ===== src/ats_stream_if.sv =====
// Valid/ready channel interfaces for sample beats and result beats.
// Depends on ats_pkg for the field widths and level type.
`default_nettype none

interface ats_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [ats_pkg::SAMPLE_W-1:0]  sample;
  logic [ats_pkg::TIME_W-1:0]           now_ms;

  modport source (output valid, output sample, output now_ms, input ready);
  modport sink   (input valid, input sample, input now_ms, output ready);
endinterface

interface ats_out_if;
  logic                           valid;
  logic                           ready;
  logic [ats_pkg::COUNT_W-1:0]    step_count;
  logic                           step_seen;
  ats_pkg::level_t                filtered_value;

  modport source (output valid, output step_count, output step_seen,
                  output filtered_value, input ready);
  modport sink   (input valid, input step_count, input step_seen,
                  input filtered_value, output ready);
endinterface

`default_nettype wire

// ===== src/adaptive_threshold_step_detector.sv =====
// Each sample passes through the sample register and then the result register; one
// sample per cycle while the result channel does not stall. The 17x33 filter multiply,
// the threshold compares and the state update all sit between the sample register and
// the result register. A stalled result register stalls the sample register.
// Reset (rst_n low, synchronous): registers, thresholds and the step count
// return to their defaults and both channels empty.
// Depends on ats_pkg and the channel interfaces in ats_stream_if.sv.
`default_nettype none

module adaptive_threshold_step_detector (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  ats_in_if.sink                                  in_chan,
  ats_out_if.source                               out_chan,
  input  wire logic                               cfg_we,
  input  wire logic [ats_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [ats_pkg::CFG_DATA_W-1:0]     cfg_data
);

  // Configuration registers.
  logic [ats_pkg::WEIGHT_W-1:0]        filter_weight_r;
  logic signed [ats_pkg::SAMPLE_W-1:0] zero_offset_r;
  ats_pkg::level_t                     top_floor_r;
  ats_pkg::level_t                     top_ceiling_r;
  ats_pkg::level_t                     bottom_ceiling_r;
  ats_pkg::level_t                     bottom_floor_r;
  logic [ats_pkg::DECAY_W-1:0]         decay_step_r;
  logic [ats_pkg::HOLD_W-1:0]          hold_ms_r;

  // Sample register.
  logic                                s1_valid_r;
  logic signed [ats_pkg::SAMPLE_W-1:0] s1_sample_r;
  logic [ats_pkg::TIME_W-1:0]          s1_now_r;

  // Detector state.
  ats_pkg::level_t                     prev_filtered_r, prev_filtered_nxt;
  logic                                primed_r;
  logic                                high_armed_r, high_armed_nxt;
  logic                                low_armed_r, low_armed_nxt;
  logic                                passing_r, passing_nxt;
  ats_pkg::level_t                     top_level_r, top_level_nxt;
  ats_pkg::level_t                     high_level_r, high_level_nxt;
  ats_pkg::level_t                     bottom_level_r, bottom_level_nxt;
  ats_pkg::level_t                     low_level_r, low_level_nxt;
  logic [ats_pkg::TIME_W-1:0]          last_step_ms_r, last_step_ms_nxt;
  logic [ats_pkg::COUNT_W-1:0]         step_total_r, step_total_nxt;
  logic                                seen_nxt;

  // Result register.
  logic                                out_valid_r;
  logic [ats_pkg::COUNT_W-1:0]         out_count_r;
  logic                                out_seen_r;
  ats_pkg::level_t                     out_filtered_r;

  logic advance;
  logic fire;

  // The pipeline moves when the result register is empty or being drained.
  assign advance = !out_valid_r || out_chan.ready;
  assign fire    = s1_valid_r && advance;
  assign in_chan.ready = !s1_valid_r || advance;

  assign out_chan.valid          = out_valid_r;
  assign out_chan.step_count     = out_count_r;
  assign out_chan.step_seen      = out_seen_r;
  assign out_chan.filtered_value = out_filtered_r;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filter_weight_r  <= ats_pkg::RST_FILTER_WEIGHT;
      zero_offset_r    <= ats_pkg::RST_ZERO_OFFSET;
      top_floor_r      <= ats_pkg::RST_TOP_FLOOR;
      top_ceiling_r    <= ats_pkg::RST_TOP_CEILING;
      bottom_ceiling_r <= ats_pkg::RST_BOTTOM_CEILING;
      bottom_floor_r   <= ats_pkg::RST_BOTTOM_FLOOR;
      decay_step_r     <= ats_pkg::RST_DECAY_STEP;
      hold_ms_r        <= ats_pkg::RST_HOLD_MS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ats_pkg::CFG_FILTER_WEIGHT:  filter_weight_r  <= cfg_data[ats_pkg::WEIGHT_W-1:0];
        ats_pkg::CFG_ZERO_OFFSET:    zero_offset_r    <= cfg_data[ats_pkg::SAMPLE_W-1:0];
        ats_pkg::CFG_TOP_FLOOR:      top_floor_r      <= cfg_data;
        ats_pkg::CFG_TOP_CEILING:    top_ceiling_r    <= cfg_data;
        ats_pkg::CFG_BOTTOM_CEILING: bottom_ceiling_r <= cfg_data;
        ats_pkg::CFG_BOTTOM_FLOOR:   bottom_floor_r   <= cfg_data;
        ats_pkg::CFG_DECAY_STEP:     decay_step_r     <= cfg_data[ats_pkg::DECAY_W-1:0];
        ats_pkg::CFG_HOLD_MS:        hold_ms_r        <= cfg_data[ats_pkg::HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  // Sample register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      s1_sample_r <= in_chan.sample;
      s1_now_r    <= in_chan.now_ms;
    end
  end

  // Offset removal and low-pass filter.
  logic signed [ats_pkg::SAMPLE_W:0] x;
  logic [ats_pkg::WEIGHT_W-1:0]      w_eff;
  logic [ats_pkg::WEIGHT_W-1:0]      w_comp;
  ats_pkg::level_t                   prev_eff;
  logic signed [50:0]                prev_prod;
  logic signed [34:0]                prev_term;
  logic signed [34:0]                new_term;
  ats_pkg::wide_t                    z_sum;
  ats_pkg::level_t                   z;
  logic [ats_pkg::TIME_W-1:0]        elapsed;

  assign x = {s1_sample_r[ats_pkg::SAMPLE_W-1], s1_sample_r}
           - {zero_offset_r[ats_pkg::SAMPLE_W-1], zero_offset_r};
  assign w_eff  = (filter_weight_r > ats_pkg::WEIGHT_ONE) ? ats_pkg::WEIGHT_ONE
                                                          : filter_weight_r;
  assign w_comp = ats_pkg::WEIGHT_ONE - w_eff;
  // The first sample primes the history with x in Q16.16.
  assign prev_eff  = primed_r ? prev_filtered_r : {x, 16'd0};
  assign prev_prod = $signed({1'b0, w_eff}) * prev_eff;
  assign prev_term = prev_prod[50:16];
  assign new_term  = $signed({1'b0, w_comp}) * x;
  assign z_sum     = {prev_term[34], prev_term} + {new_term[34], new_term};
  assign z         = ats_pkg::sat_level(z_sum);
  assign elapsed   = s1_now_r - last_step_ms_r;

  // Threshold tracking and step decision.
  always_comb begin
    ats_pkg::level_t top_d, high_d, bottom_d, low_d;
    logic            high_armed_a, low_armed_a, passing_a;

    // Decay while armed.
    top_d  = top_level_r;
    high_d = high_level_r;
    if (high_armed_r && top_level_r > top_floor_r) begin
      top_d  = ats_pkg::level_sub(top_level_r, decay_step_r);
      high_d = top_d;
    end
    bottom_d = bottom_level_r;
    low_d    = low_level_r;
    if (low_armed_r && bottom_level_r < bottom_ceiling_r) begin
      bottom_d = ats_pkg::level_add(bottom_level_r, decay_step_r);
      low_d    = ats_pkg::level_neg(bottom_d);
    end

    // Disarm on crossing.
    high_armed_a = high_armed_r;
    if (high_armed_r && elapsed > {16'd0, hold_ms_r} && z > high_d) begin
      high_armed_a = 1'b0;
    end
    low_armed_a = low_armed_r;
    if (low_armed_r && z < low_d && passing_r) begin
      low_armed_a = 1'b0;
    end

    top_level_nxt    = top_d;
    high_level_nxt   = high_d;
    high_armed_nxt   = high_armed_a;
    passing_a        = passing_r;
    bottom_level_nxt = bottom_d;
    low_level_nxt    = low_d;
    low_armed_nxt    = low_armed_a;
    step_total_nxt   = step_total_r;
    last_step_ms_nxt = last_step_ms_r;
    seen_nxt         = 1'b0;

    // Peak follow or fall back through the high level.
    if (!high_armed_a) begin
      if (z > top_d) begin
        top_level_nxt  = (z > top_ceiling_r) ? top_ceiling_r : z;
        high_level_nxt = top_level_nxt;
      end else if (high_d > z) begin
        high_armed_nxt = 1'b1;
        passing_a      = 1'b1;
      end
    end
    passing_nxt = passing_a;

    // Valley follow or recovery, which completes a step.
    if (!low_armed_a && passing_a) begin
      if (z < bottom_d) begin
        bottom_level_nxt = (z < bottom_floor_r) ? bottom_floor_r : z;
        low_level_nxt    = ats_pkg::level_neg(bottom_level_nxt);
      end else if (low_d < z) begin
        low_armed_nxt    = 1'b1;
        passing_nxt      = 1'b0;
        if (step_total_r != ats_pkg::COUNT_MAX) begin
          step_total_nxt = step_total_r + 1'b1;
        end
        last_step_ms_nxt = s1_now_r;
        seen_nxt         = 1'b1;
      end
    end

    prev_filtered_nxt = z;
  end

  // Detector state update, one sample per fire.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_filtered_r <= '0;
      primed_r        <= 1'b0;
      high_armed_r    <= 1'b1;
      low_armed_r     <= 1'b1;
      passing_r       <= 1'b0;
      top_level_r     <= ats_pkg::LEVEL_ONE;
      high_level_r    <= '0;
      bottom_level_r  <= ats_pkg::LEVEL_NEG_ONE;
      low_level_r     <= '0;
      last_step_ms_r  <= '0;
      step_total_r    <= '0;
    end else if (fire) begin
      prev_filtered_r <= prev_filtered_nxt;
      primed_r        <= 1'b1;
      high_armed_r    <= high_armed_nxt;
      low_armed_r     <= low_armed_nxt;
      passing_r       <= passing_nxt;
      top_level_r     <= top_level_nxt;
      high_level_r    <= high_level_nxt;
      bottom_level_r  <= bottom_level_nxt;
      low_level_r     <= low_level_nxt;
      last_step_ms_r  <= last_step_ms_nxt;
      step_total_r    <= step_total_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_count_r    <= step_total_nxt;
      out_seen_r     <= seen_nxt;
      out_filtered_r <= z;
    end
  end

  // A disarmed low detector always has a pass in progress.
  a_low_implies_passing: assert property (@(posedge clk) disable iff (!rst_n)
    !low_armed_r |-> passing_r)
    else $error("low detector disarmed without a pass in progress");

  // A result that reports a step never carries a zero count.
  a_seen_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_seen_r |-> out_count_r != '0)
    else $error("step reported with zero count");

  // The step count only moves when a sample is processed.
  a_count_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !fire |=> $stable(step_total_r))
    else $error("step count changed without a sample");

  // The filter history is primed after the first processed sample.
  a_primed: assert property (@(posedge clk) disable iff (!rst_n)
    fire |=> primed_r)
    else $error("filter not primed after a sample");

  // A held sample register with a blocked result stays loaded.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !advance |=> s1_valid_r && $stable(s1_now_r))
    else $error("stalled sample lost");

endmodule

`default_nettype wire

// ===== dv/adaptive_threshold_step_detector_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the adaptive-threshold step detector: a queued
// sample driver, a result monitor with a built-in predictor, and register sweeps.
// Depends on ats_pkg, ats_stream_if.sv and adaptive_threshold_step_detector.sv.

module adaptive_threshold_step_detector_tb;

  typedef struct packed {
    logic signed [ats_pkg::SAMPLE_W-1:0] sample;
    logic [ats_pkg::TIME_W-1:0]          now_ms;
  } sample_beat_t;

  typedef struct packed {
    logic [ats_pkg::COUNT_W-1:0] step_count;
    logic                        step_seen;
    ats_pkg::level_t             filtered_value;
  } step_result_t;

  localparam longint LVL_MAX     = 64'sd4294967295;
  localparam longint LVL_MIN     = -64'sd4294967296;
  localparam int     STALL_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  ats_pkg::cfg_idx_t cfg_index;
  logic [ats_pkg::CFG_DATA_W-1:0] cfg_data;

  ats_in_if  in_if ();
  ats_out_if out_if ();

  adaptive_threshold_step_detector u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_if),
    .out_chan  (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Stimulus and scoreboard storage.
  sample_beat_t samples_to_send[$];
  step_result_t step_results_due[$];
  sample_beat_t drv_beat;
  int samples_queued = 0;
  int samples_taken = 0;
  int mismatches = 0;
  int stall_cycles = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit sample_beat_taken = 1'b0;
  logic [ats_pkg::TIME_W-1:0] gen_now = 32'd200;

  // Predictor copy of the registers.
  logic [ats_pkg::WEIGHT_W-1:0] cf_weight = ats_pkg::RST_FILTER_WEIGHT;
  longint cf_offset         = longint'(ats_pkg::RST_ZERO_OFFSET);
  longint cf_top_floor      = longint'(ats_pkg::RST_TOP_FLOOR);
  longint cf_top_ceiling    = longint'(ats_pkg::RST_TOP_CEILING);
  longint cf_bottom_ceiling = longint'(ats_pkg::RST_BOTTOM_CEILING);
  longint cf_bottom_floor   = longint'(ats_pkg::RST_BOTTOM_FLOOR);
  longint cf_decay          = longint'(ats_pkg::RST_DECAY_STEP);
  longint cf_hold           = longint'(ats_pkg::RST_HOLD_MS);

  // Predictor copy of the detector state.
  longint st_prev   = 0;
  bit     st_primed = 1'b0;
  bit     st_high_armed = 1'b1;
  bit     st_low_armed  = 1'b1;
  bit     st_passing    = 1'b0;
  longint st_top    = longint'(ats_pkg::LEVEL_ONE);
  longint st_high   = 0;
  longint st_bottom = longint'(ats_pkg::LEVEL_NEG_ONE);
  longint st_low    = 0;
  logic [ats_pkg::TIME_W-1:0]  st_last_ms = '0;
  logic [ats_pkg::COUNT_W-1:0] st_count   = '0;

  // Clock: 10 ns period.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint clamp_level(input longint v);
    if (v > LVL_MAX) return LVL_MAX;
    if (v < LVL_MIN) return LVL_MIN;
    return v;
  endfunction

  // Mirror one register write into the predictor.
  function automatic void load_reg(input ats_pkg::cfg_idx_t idx,
                                   input logic [ats_pkg::CFG_DATA_W-1:0] d);
    case (idx)
      ats_pkg::CFG_FILTER_WEIGHT:  cf_weight = d[ats_pkg::WEIGHT_W-1:0];
      ats_pkg::CFG_ZERO_OFFSET:    cf_offset = longint'($signed(d[ats_pkg::SAMPLE_W-1:0]));
      ats_pkg::CFG_TOP_FLOOR:      cf_top_floor = longint'($signed(d));
      ats_pkg::CFG_TOP_CEILING:    cf_top_ceiling = longint'($signed(d));
      ats_pkg::CFG_BOTTOM_CEILING: cf_bottom_ceiling = longint'($signed(d));
      ats_pkg::CFG_BOTTOM_FLOOR:   cf_bottom_floor = longint'($signed(d));
      ats_pkg::CFG_DECAY_STEP:     cf_decay = longint'(d[ats_pkg::DECAY_W-1:0]);
      ats_pkg::CFG_HOLD_MS:        cf_hold = longint'(d[ats_pkg::HOLD_W-1:0]);
      default: ;
    endcase
  endfunction

  // Filter one sample, move the thresholds and detect a completed step.
  function automatic step_result_t detect_step(
      input logic signed [ats_pkg::SAMPLE_W-1:0] smp,
      input logic [ats_pkg::TIME_W-1:0] now);
    longint x;
    longint w;
    longint z;
    logic [ats_pkg::TIME_W-1:0] since_step;
    logic seen;
    step_result_t r;
    x = longint'(smp) - cf_offset;
    since_step = now - st_last_ms;
    w = (cf_weight > ats_pkg::WEIGHT_ONE) ? 64'sd65536 : longint'(cf_weight);
    seen = 1'b0;
    // The very first sample seeds the filter history.
    if (!st_primed) begin
      st_prev = x * 65536;
      st_primed = 1'b1;
    end
    // Armed thresholds relax toward their limits.
    if (st_high_armed && st_top > cf_top_floor) begin
      st_top = clamp_level(st_top - cf_decay);
      st_high = st_top;
    end
    if (st_low_armed && st_bottom < cf_bottom_ceiling) begin
      st_bottom = clamp_level(st_bottom + cf_decay);
      st_low = clamp_level(-st_bottom);
    end
    // Arithmetic shift of the weighted product rounds toward minus infinity.
    z = clamp_level(((w * st_prev) >>> 16) + (65536 - w) * x);
    if (st_high_armed && longint'(since_step) > cf_hold && z > st_high) begin
      st_high_armed = 1'b0;
    end
    if (st_low_armed && z < st_low && st_passing) begin
      st_low_armed = 1'b0;
    end
    // Top follows the peak, then re-arms once the signal falls back.
    if (!st_high_armed) begin
      if (z > st_top) begin
        st_top = (z > cf_top_ceiling) ? cf_top_ceiling : z;
        st_high = st_top;
      end else if (st_high > z) begin
        st_high_armed = 1'b1;
        st_passing = 1'b1;
      end
    end
    // Bottom follows the valley; the recovery completes the step.
    if (!st_low_armed && st_passing) begin
      if (z < st_bottom) begin
        st_bottom = (z < cf_bottom_floor) ? cf_bottom_floor : z;
        st_low = clamp_level(-st_bottom);
      end else if (st_low < z) begin
        st_low_armed = 1'b1;
        st_passing = 1'b0;
        if (st_count != ats_pkg::COUNT_MAX) begin
          st_count = st_count + 1'b1;
        end
        st_last_ms = now;
        seen = 1'b1;
      end
    end
    st_prev = z;
    r.step_count = st_count;
    r.step_seen = seen;
    r.filtered_value = z[ats_pkg::LEVEL_W-1:0];
    return r;
  endfunction

  // Sample driver: holds a beat until it is taken, idles at random between beats.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || sample_beat_taken) begin
      if (samples_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        drv_beat = samples_to_send.pop_front();
        in_if.valid <= 1'b1;
        in_if.sample <= drv_beat.sample;
        in_if.now_ms <= drv_beat.now_ms;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Result receiver stalls at random.
  always @(negedge clk) begin
    out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Monitor: predict on each sample beat, check each result beat.
  always @(posedge clk) begin : monitor
    step_result_t want;
    step_result_t got;
    bit result_beat;
    if (rst_n) begin
      if (cfg_we) begin
        load_reg(cfg_index, cfg_data);
      end
      sample_beat_taken = in_if.valid && in_if.ready;
      if (sample_beat_taken) begin
        step_results_due.push_back(detect_step(in_if.sample, in_if.now_ms));
        samples_taken++;
      end
      result_beat = out_if.valid && out_if.ready;
      if (result_beat) begin
        got.step_count = out_if.step_count;
        got.step_seen = out_if.step_seen;
        got.filtered_value = out_if.filtered_value;
        if (step_results_due.size() == 0) begin
          $display("%0t: unexpected result beat: count %0d seen %0d filtered %0d",
                   $time, got.step_count, got.step_seen, got.filtered_value);
          mismatches++;
        end else begin
          want = step_results_due.pop_front();
          if (got.step_count !== want.step_count) begin
            $display("%0t: step_count expected %0d, got %0d",
                     $time, want.step_count, got.step_count);
            mismatches++;
          end
          if (got.step_seen !== want.step_seen) begin
            $display("%0t: step_seen expected %0d, got %0d",
                     $time, want.step_seen, got.step_seen);
            mismatches++;
          end
          if (got.filtered_value !== want.filtered_value) begin
            $display("%0t: filtered_value expected %0d, got %0d",
                     $time, want.filtered_value, got.filtered_value);
            mismatches++;
          end
        end
      end
      if (sample_beat_taken || result_beat || cfg_we) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
    end
  end

  // Watchdog on cycles without any accepted beat.
  initial begin : watchdog
    wait (stall_cycles >= STALL_LIMIT);
    $display("adaptive_threshold_step_detector test failed");
    $finish;
  end

  task automatic write_reg(input ats_pkg::cfg_idx_t idx,
                           input logic [ats_pkg::CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_sample(input int value, input logic [ats_pkg::TIME_W-1:0] t);
    int v;
    sample_beat_t b;
    v = value;
    if (v > 32767) v = 32767;
    else if (v < -32768) v = -32768;
    b.sample = v[ats_pkg::SAMPLE_W-1:0];
    b.now_ms = t;
    samples_to_send.push_back(b);
    samples_queued++;
  endtask

  // Triangle wave around a center, with mostly small time steps.
  task automatic queue_wave(input int center, input int amp, input int period, input int reps);
    int n;
    int k;
    int v;
    for (n = 0; n < reps; n++) begin
      for (k = 0; k < period; k++) begin
        if (2 * k < period) v = -amp + (4 * amp * k) / period;
        else v = 3 * amp - (4 * amp * k) / period;
        gen_now += ($urandom_range(9) == 0) ? $urandom_range(3000) : $urandom_range(60);
        queue_sample(center + v, gen_now);
      end
    end
  endtask

  // Sender stays quiet until every sample has its result back.
  task automatic wait_for_results();
    do @(negedge clk);
    while (samples_taken != samples_queued || step_results_due.size() != 0);
  endtask

  task automatic start_phase(input int send_pct, input int recv_pct);
    @(posedge clk);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  // Random phase: mostly step-like waves, some raw noise and time jumps.
  task automatic run_phase(input int n_items, input int send_pct, input int recv_pct);
    int first;
    int center;
    int amp;
    int sel;
    start_phase(send_pct, recv_pct);
    first = samples_queued;
    while (samples_queued - first < n_items) begin
      sel = $urandom_range(9);
      if (sel < 2) begin
        repeat ($urandom_range(5, 1)) begin
          if ($urandom_range(3) == 0) gen_now = $urandom();
          else gen_now += $urandom_range(200);
          queue_sample(int'($urandom_range(65535)) - 32768, gen_now);
        end
      end else begin
        sel = $urandom_range(9);
        if (sel < 5) amp = $urandom_range(200, 2);
        else if (sel < 8) amp = $urandom_range(5000, 200);
        else amp = $urandom_range(32767, 5000);
        center = int'(cf_offset) + int'($urandom_range(6)) - 3;
        queue_wave(center, amp, $urandom_range(40, 6), $urandom_range(4, 1));
      end
    end
    // Trim the last wave so the phase sends exactly its share of samples.
    while (samples_queued - first > n_items) begin
      void'(samples_to_send.pop_back());
      samples_queued--;
    end
    wait_for_results();
  endtask

  function automatic longint any_level();
    return longint'($signed({1'($urandom_range(1)), 32'($urandom())}));
  endfunction

  // Register settings, from defaults through the extremes to random mixes.
  task automatic choose_setting(input int k);
    longint lvl;
    case (k)
      0: begin
        write_reg(ats_pkg::CFG_FILTER_WEIGHT, 33'(ats_pkg::RST_FILTER_WEIGHT));
        write_reg(ats_pkg::CFG_ZERO_OFFSET, 33'(ats_pkg::RST_ZERO_OFFSET));
        write_reg(ats_pkg::CFG_TOP_FLOOR, ats_pkg::RST_TOP_FLOOR);
        write_reg(ats_pkg::CFG_TOP_CEILING, ats_pkg::RST_TOP_CEILING);
        write_reg(ats_pkg::CFG_BOTTOM_CEILING, ats_pkg::RST_BOTTOM_CEILING);
        write_reg(ats_pkg::CFG_BOTTOM_FLOOR, ats_pkg::RST_BOTTOM_FLOOR);
        write_reg(ats_pkg::CFG_DECAY_STEP, 33'(ats_pkg::RST_DECAY_STEP));
        write_reg(ats_pkg::CFG_HOLD_MS, 33'(ats_pkg::RST_HOLD_MS));
      end
      1: begin
        write_reg(ats_pkg::CFG_FILTER_WEIGHT, '0);
        write_reg(ats_pkg::CFG_ZERO_OFFSET, -33'sd32768);
        write_reg(ats_pkg::CFG_DECAY_STEP, 33'd65535);
        write_reg(ats_pkg::CFG_HOLD_MS, '0);
      end
      2: begin
        write_reg(ats_pkg::CFG_FILTER_WEIGHT, 33'(ats_pkg::WEIGHT_ONE));
        write_reg(ats_pkg::CFG_ZERO_OFFSET, 33'sd32767);
        write_reg(ats_pkg::CFG_TOP_FLOOR, '0);
        write_reg(ats_pkg::CFG_TOP_CEILING, 33'sd262144);
      end
      3: begin
        // Weight above one, widest level limits, no decay, longest hold.
        write_reg(ats_pkg::CFG_FILTER_WEIGHT, 33'h1FFFF);
        write_reg(ats_pkg::CFG_ZERO_OFFSET, '0);
        write_reg(ats_pkg::CFG_TOP_FLOOR, LVL_MIN[ats_pkg::CFG_DATA_W-1:0]);
        write_reg(ats_pkg::CFG_TOP_CEILING, LVL_MAX[ats_pkg::CFG_DATA_W-1:0]);
        write_reg(ats_pkg::CFG_BOTTOM_CEILING, LVL_MAX[ats_pkg::CFG_DATA_W-1:0]);
        write_reg(ats_pkg::CFG_BOTTOM_FLOOR, LVL_MIN[ats_pkg::CFG_DATA_W-1:0]);
        write_reg(ats_pkg::CFG_DECAY_STEP, '0);
        write_reg(ats_pkg::CFG_HOLD_MS, 33'd65535);
      end
      default: begin
        if ($urandom_range(3) == 0) begin
          write_reg(ats_pkg::CFG_FILTER_WEIGHT, 33'($urandom_range(131071)));
        end else begin
          write_reg(ats_pkg::CFG_FILTER_WEIGHT, 33'($urandom_range(65536, 40000)));
        end
        if ($urandom_range(3) == 0) begin
          write_reg(ats_pkg::CFG_ZERO_OFFSET, 33'($urandom_range(65535)));
        end else begin
          write_reg(ats_pkg::CFG_ZERO_OFFSET, 33'(int'($urandom_range(4000)) - 2000));
        end
        if ($urandom_range(3) == 0) begin
          write_reg(ats_pkg::CFG_TOP_FLOOR, 33'(any_level()));
          write_reg(ats_pkg::CFG_TOP_CEILING, 33'(any_level()));
          write_reg(ats_pkg::CFG_BOTTOM_CEILING, 33'(any_level()));
          write_reg(ats_pkg::CFG_BOTTOM_FLOOR, 33'(any_level()));
        end else begin
          lvl = longint'($urandom_range(131072));
          write_reg(ats_pkg::CFG_TOP_FLOOR, 33'(lvl));
          write_reg(ats_pkg::CFG_TOP_CEILING, 33'(lvl + longint'($urandom_range(200000))));
          lvl = -longint'($urandom_range(131072));
          write_reg(ats_pkg::CFG_BOTTOM_CEILING, 33'(lvl));
          write_reg(ats_pkg::CFG_BOTTOM_FLOOR, 33'(lvl - longint'($urandom_range(200000))));
        end
        if ($urandom_range(1) == 0) begin
          write_reg(ats_pkg::CFG_DECAY_STEP, 33'($urandom_range(65535)));
        end else begin
          write_reg(ats_pkg::CFG_DECAY_STEP, 33'($urandom_range(200)));
        end
        if ($urandom_range(1) == 0) begin
          write_reg(ats_pkg::CFG_HOLD_MS, 33'($urandom_range(65535)));
        end else begin
          write_reg(ats_pkg::CFG_HOLD_MS, 33'($urandom_range(300)));
        end
      end
    endcase
  endtask

  // Directed samples: priming, one clean step, field extremes and a time wrap.
  task automatic queue_directed();
    int i;
    queue_sample(int'(ats_pkg::RST_ZERO_OFFSET), gen_now);
    for (i = 0; i < 6; i++) begin
      gen_now += 30;
      queue_sample(int'(ats_pkg::RST_ZERO_OFFSET) + 60, gen_now);
    end
    for (i = 0; i < 8; i++) begin
      gen_now += 30;
      queue_sample(int'(ats_pkg::RST_ZERO_OFFSET) - 60, gen_now);
    end
    for (i = 0; i < 6; i++) begin
      gen_now += 30;
      queue_sample(int'(ats_pkg::RST_ZERO_OFFSET) + 60, gen_now);
    end
    queue_sample(int'(ats_pkg::RST_ZERO_OFFSET), gen_now);
    queue_sample(32767, 32'hFFFF_FFFF);
    queue_sample(-32768, 32'h0000_0000);
    queue_sample(0, 32'h0000_0000);
  endtask

  initial begin
    int setting;
    in_if.valid = 1'b0;
    in_if.sample = '0;
    in_if.now_ms = '0;
    out_if.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = ats_pkg::CFG_FILTER_WEIGHT;
    cfg_data = '0;
    rst_n = 1'b0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    start_phase(18, 87);
    queue_directed();
    wait_for_results();

    for (setting = 0; setting < 8; setting++) begin
      choose_setting(setting);
      if (setting < 3) run_phase(80, 18, 87);
      else if (setting < 6) run_phase(80, 87, 18);
      else run_phase(80, 0, 0);
    end

    // Let any stray result beat show up before the verdict.
    repeat (8) @(negedge clk);
    if (step_results_due.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, step_results_due.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("adaptive_threshold_step_detector test passed");
    end else begin
      $display("adaptive_threshold_step_detector test failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/ats_pkg.sv
src/ats_stream_if.sv
src/adaptive_threshold_step_detector.sv
dv/adaptive_threshold_step_detector_tb.sv
